// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the tokenizer RTL.
// Defining NO_ASSERTIONS turns every check into an empty statement.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clock, reset, cond) \
  label: assert property (@(posedge clock) disable iff (reset) (cond)) \
    else $error("assertion failed: condition does not hold");

// Checks that a trigger is followed by a consequence on the next edge.
`define ASSERT_NEXT(label, clock, reset, trig, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
    else $error("assertion failed: consequence missing on next cycle");

`else

`define ASSERT_ALWAYS(label, clock, reset, cond)
`define ASSERT_NEXT(label, clock, reset, trig, cons)

`endif

`endif

// ===== sv/ist_pkg.sv =====
// ---------------------------------------------------------------------------
// ist_pkg
// Byte classes, character constants, parser states, event codes, the result
// record, the byte classifier and the next-state table of the INI stream tokenizer.
// ---------------------------------------------------------------------------
package ist_pkg;

  // Byte classes.
  typedef logic [2:0] class_t;
  localparam class_t CL_EOL = 3'd0;
  localparam class_t CL_LBR = 3'd1;
  localparam class_t CL_RBR = 3'd2;
  localparam class_t CL_EQ  = 3'd3;
  localparam class_t CL_SP  = 3'd4;
  localparam class_t CL_PRN = 3'd5;
  localparam class_t CL_OTH = 3'd6;

  // Parser states.
  typedef logic [3:0] state_t;
  localparam state_t ST_LINE   = 4'd0;  // start of line, no section
  localparam state_t ST_OPEN   = 4'd1;  // after '['
  localparam state_t ST_DROP   = 4'd2;  // dropping a bad line, no section
  localparam state_t ST_SNAME  = 4'd3;  // inside a section name
  localparam state_t ST_SCLOSE = 4'd4;  // after ']'
  localparam state_t ST_KLINE  = 4'd5;  // start of line inside a section
  localparam state_t ST_KNAME  = 4'd6;  // inside a key
  localparam state_t ST_KDROP  = 4'd7;  // dropping a bad line inside a section
  localparam state_t ST_AFTEQ  = 4'd8;  // after '='
  localparam state_t ST_VNAME  = 4'd9;  // inside a value

  // Event codes.
  typedef logic [2:0] event_t;
  localparam event_t EV_NONE = 3'd0;
  localparam event_t EV_SEC  = 3'd1;
  localparam event_t EV_KEY  = 3'd2;
  localparam event_t EV_VAL  = 3'd3;
  localparam event_t EV_PAIR = 3'd4;

  // Character constants.
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LBR    = 8'h5B;
  localparam logic [7:0] CH_RBR    = 8'h5D;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_CTLMAX = 8'd31;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] SPACE_MAX = 8'hFF;

  // One result item.
  typedef struct packed {
    logic [7:0] spaces_before;
    logic       starts_name;
    logic [7:0] char_out;
    event_t     event_res;
  } result_t;

  // Sorts a raw byte into its class.
  function automatic class_t classify(input logic [7:0] b);
    class_t cl;
    if (b == CH_LF || b == CH_CR) cl = CL_EOL;
    else if (b == CH_LBR) cl = CL_LBR;
    else if (b == CH_RBR) cl = CL_RBR;
    else if (b == CH_EQ) cl = CL_EQ;
    else if (b == CH_SP) cl = CL_SP;
    else if (b > CH_CTLMAX && b < CH_DEL) cl = CL_PRN;
    else cl = CL_OTH;
    return cl;
  endfunction

  // Next parser state for a state and a byte class.
  function automatic state_t next_state(input state_t st, input class_t cl);
    state_t ns;
    ns = ST_LINE;
    unique case (st)
      ST_OPEN: begin
        if (cl == CL_EOL) ns = ST_LINE;
        else if (cl == CL_SP) ns = ST_OPEN;
        else if (cl == CL_PRN) ns = ST_SNAME;
        else ns = ST_DROP;
      end
      ST_DROP: begin
        ns = (cl == CL_EOL) ? ST_LINE : ST_DROP;
      end
      ST_SNAME: begin
        if (cl == CL_EOL) ns = ST_LINE;
        else if (cl == CL_RBR) ns = ST_SCLOSE;
        else if (cl == CL_SP || cl == CL_PRN) ns = ST_SNAME;
        else ns = ST_DROP;
      end
      ST_SCLOSE: begin
        ns = (cl == CL_EOL) ? ST_KLINE : ST_SCLOSE;
      end
      ST_KLINE: begin
        if (cl == CL_EOL || cl == CL_SP) ns = ST_KLINE;
        else if (cl == CL_LBR) ns = ST_OPEN;
        else if (cl == CL_PRN) ns = ST_KNAME;
        else ns = ST_KDROP;
      end
      ST_KNAME: begin
        if (cl == CL_EOL) ns = ST_KLINE;
        else if (cl == CL_EQ) ns = ST_AFTEQ;
        else if (cl == CL_SP || cl == CL_PRN) ns = ST_KNAME;
        else ns = ST_KDROP;
      end
      ST_KDROP: begin
        ns = (cl == CL_EOL) ? ST_KLINE : ST_KDROP;
      end
      ST_AFTEQ: begin
        if (cl == CL_EOL) ns = ST_KLINE;
        else if (cl == CL_SP) ns = ST_AFTEQ;
        else if (cl == CL_EQ || cl == CL_OTH) ns = ST_KDROP;
        else ns = ST_VNAME;
      end
      ST_VNAME: begin
        if (cl == CL_EOL) ns = ST_KLINE;
        else if (cl == CL_EQ || cl == CL_OTH) ns = ST_KDROP;
        else ns = ST_VNAME;
      end
      default: begin
        // Start of line, and any code that is not a state.
        if (cl == CL_EOL || cl == CL_SP) ns = ST_LINE;
        else if (cl == CL_LBR) ns = ST_OPEN;
        else ns = ST_DROP;
      end
    endcase
    return ns;
  endfunction

endpackage

// ===== sv/ist_fsm.sv =====
// ---------------------------------------------------------------------------
// ist_fsm
// Parser state and held-space counter. Produces the result for the byte on
// its input in the same cycle and advances its state when told to.
// ---------------------------------------------------------------------------
module ist_fsm (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       byte_in,
  input  logic             end_of_stream,
  output ist_pkg::result_t result
);

  ist_pkg::state_t parse_state;
  ist_pkg::state_t parse_state_next;
  logic [7:0]      pending_spaces;
  logic [7:0]      pending_spaces_next;

  ist_pkg::state_t st;
  ist_pkg::class_t cl;
  ist_pkg::event_t ev;
  logic            start;
  logic            hold;
  logic            is_char;
  logic            is_name;
  logic            is_vchar;

  // Out-of-range codes fall back to start of line.
  assign st = (parse_state > ist_pkg::ST_VNAME) ? ist_pkg::ST_LINE : parse_state;
  assign cl = ist_pkg::classify(byte_in);
  assign is_name  = (cl == ist_pkg::CL_PRN);
  assign is_vchar = (cl == ist_pkg::CL_PRN || cl == ist_pkg::CL_LBR ||
                     cl == ist_pkg::CL_RBR);

  // Tagging of the current byte.
  always_comb begin
    ev    = ist_pkg::EV_NONE;
    start = 1'b0;
    hold  = 1'b0;
    if (end_of_stream) begin
      if (st == ist_pkg::ST_VNAME) ev = ist_pkg::EV_PAIR;
    end else begin
      unique case (st)
        ist_pkg::ST_OPEN: begin
          if (is_name) begin
            ev    = ist_pkg::EV_SEC;
            start = 1'b1;
          end
        end
        ist_pkg::ST_SNAME: begin
          if (is_name) ev = ist_pkg::EV_SEC;
          else if (cl == ist_pkg::CL_SP) hold = 1'b1;
        end
        ist_pkg::ST_KLINE: begin
          if (is_name) begin
            ev    = ist_pkg::EV_KEY;
            start = 1'b1;
          end
        end
        ist_pkg::ST_KNAME: begin
          if (is_name) ev = ist_pkg::EV_KEY;
          else if (cl == ist_pkg::CL_SP) hold = 1'b1;
        end
        ist_pkg::ST_AFTEQ: begin
          if (is_vchar) begin
            ev    = ist_pkg::EV_VAL;
            start = 1'b1;
          end
        end
        ist_pkg::ST_VNAME: begin
          if (is_vchar) ev = ist_pkg::EV_VAL;
          else if (cl == ist_pkg::CL_SP) hold = 1'b1;
          else ev = ist_pkg::EV_PAIR;
        end
        default: begin
        end
      endcase
    end
  end

  // Result fields: character and space count only for character events.
  assign is_char = (ev == ist_pkg::EV_SEC || ev == ist_pkg::EV_KEY ||
                    ev == ist_pkg::EV_VAL);
  assign result.event_res     = ev;
  assign result.starts_name   = start;
  assign result.char_out      = is_char ? byte_in : 8'd0;
  assign result.spaces_before = (is_char && !start) ? pending_spaces : 8'd0;

  // Next state and saturating space count.
  always_comb begin
    if (end_of_stream) begin
      parse_state_next    = ist_pkg::ST_LINE;
      pending_spaces_next = 8'd0;
    end else begin
      parse_state_next = ist_pkg::next_state(st, cl);
      if (!hold) pending_spaces_next = 8'd0;
      else if (pending_spaces != ist_pkg::SPACE_MAX) pending_spaces_next = pending_spaces + 8'd1;
      else pending_spaces_next = pending_spaces;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state    <= ist_pkg::ST_LINE;
      pending_spaces <= 8'd0;
    end else if (advance) begin
      parse_state    <= parse_state_next;
      pending_spaces <= pending_spaces_next;
    end
  end

endmodule

// ===== sv/ini_stream_tokenizer.sv =====
// ---------------------------------------------------------------------------
// ini_stream_tokenizer
// Streaming INI tokenizer: tags each byte as section, key or value text, or
// reports a completed key/value pair, one result per byte.
// ---------------------------------------------------------------------------
//  Channel | Dir | tdata                          | tuser                     | tlast
//  s_*     | in  | [7:0] byte_in                  | -                         | end_of_stream
//  m_*     | out | [7:0] char_out, [15:8] spaces  | [2:0] event, [3] starts   | -
//
// One byte per cycle while s_tready is high; the result is registered in the
// output stage. The parser state is registered and updates from a small table.
// A two-entry output stage (main plus skid register) lets requests keep
// flowing while one result waits; s_tready drops only when both are full.
// Synchronous reset returns the parser to start of line with no section and
// empties the output stage.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ini_stream_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic        s_tlast,   // end_of_stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] char_out, [15:8] spaces_before
  output logic [3:0]  m_tuser    // [2:0] event_res, [3] starts_name
);

  logic              accept;
  ist_pkg::result_t  new_result;
  ist_pkg::result_t  main_result;
  ist_pkg::result_t  skid_result;
  logic              skid_valid;

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;

  // Parser.
  ist_fsm u_fsm (
    .clk           (clk),
    .rst           (rst),
    .advance       (accept),
    .byte_in       (s_tdata),
    .end_of_stream (s_tlast),
    .result        (new_result)
  );

  // Output stage with skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      if (skid_valid) main_result <= skid_result;
      else if (accept) main_result <= new_result;
    end else if (accept) begin
      skid_result <= new_result;
    end
  end

  assign m_tdata = {main_result.spaces_before, main_result.char_out};
  assign m_tuser = {main_result.starts_name, main_result.event_res};

  // Checks on the output stage and result fields.
  `ASSERT_ALWAYS(a_skid_behind_main, clk, rst, !skid_valid || m_tvalid)
  `ASSERT_NEXT(a_skid_drains, clk, rst, skid_valid && m_tready, m_tvalid && !skid_valid)
  `ASSERT_ALWAYS(a_start_no_spaces, clk, rst, !(m_tvalid && m_tuser[3]) || m_tdata[15:8] == 8'd0)
  `ASSERT_ALWAYS(a_quiet_fields, clk, rst,
    !(m_tvalid && (m_tuser[2:0] == ist_pkg::EV_NONE || m_tuser[2:0] == ist_pkg::EV_PAIR)) ||
    (m_tdata == 16'd0 && !m_tuser[3]))

endmodule

// ===== bench/ini_stream_tokenizer_check.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ini_stream_tokenizer_check
// Watches both stream channels of the INI tokenizer. It runs its own copy of
// the parser on every accepted request, queues the predicted token, and
// compares each delivered token field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module ini_stream_tokenizer_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic        s_tlast,   // end_of_stream
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [7:0] char_out, [15:8] spaces_before
  input  logic [3:0]  m_tuser,   // [2:0] event_res, [3] starts_name
  output int          errors,
  output int          pending,
  output int          checked,
  output int          pairs
);

  // Tokens predicted but not yet delivered, oldest first.
  ist_pkg::result_t token_q[$];

  // Parser state of the predictor.
  ist_pkg::state_t tok_state;
  logic [7:0]      held_spaces;

  // Sorts a raw byte into its class.
  function automatic ist_pkg::class_t byte_class(input logic [7:0] b);
    ist_pkg::class_t cl;
    unique case (b)
      ist_pkg::CH_LF, ist_pkg::CH_CR: cl = ist_pkg::CL_EOL;
      ist_pkg::CH_LBR:                cl = ist_pkg::CL_LBR;
      ist_pkg::CH_RBR:                cl = ist_pkg::CL_RBR;
      ist_pkg::CH_EQ:                 cl = ist_pkg::CL_EQ;
      ist_pkg::CH_SP:                 cl = ist_pkg::CL_SP;
      default: begin
        if (b > ist_pkg::CH_CTLMAX && b < ist_pkg::CH_DEL) cl = ist_pkg::CL_PRN;
        else cl = ist_pkg::CL_OTH;
      end
    endcase
    return cl;
  endfunction

  // Parser state after one byte of a given class.
  function automatic ist_pkg::state_t follow(input ist_pkg::state_t st,
                                             input ist_pkg::class_t cl);
    ist_pkg::state_t n;
    unique case (st)
      ist_pkg::ST_LINE:
        unique case (cl)
          ist_pkg::CL_EOL, ist_pkg::CL_SP: n = ist_pkg::ST_LINE;
          ist_pkg::CL_LBR:                 n = ist_pkg::ST_OPEN;
          default:                         n = ist_pkg::ST_DROP;
        endcase
      ist_pkg::ST_OPEN:
        unique case (cl)
          ist_pkg::CL_EOL: n = ist_pkg::ST_LINE;
          ist_pkg::CL_SP:  n = ist_pkg::ST_OPEN;
          ist_pkg::CL_PRN: n = ist_pkg::ST_SNAME;
          default:         n = ist_pkg::ST_DROP;
        endcase
      ist_pkg::ST_DROP:
        n = (cl == ist_pkg::CL_EOL) ? ist_pkg::ST_LINE : ist_pkg::ST_DROP;
      ist_pkg::ST_SNAME:
        unique case (cl)
          ist_pkg::CL_EOL:                  n = ist_pkg::ST_LINE;
          ist_pkg::CL_RBR:                  n = ist_pkg::ST_SCLOSE;
          ist_pkg::CL_SP, ist_pkg::CL_PRN:  n = ist_pkg::ST_SNAME;
          default:                          n = ist_pkg::ST_DROP;
        endcase
      ist_pkg::ST_SCLOSE:
        n = (cl == ist_pkg::CL_EOL) ? ist_pkg::ST_KLINE : ist_pkg::ST_SCLOSE;
      ist_pkg::ST_KLINE:
        unique case (cl)
          ist_pkg::CL_EOL, ist_pkg::CL_SP: n = ist_pkg::ST_KLINE;
          ist_pkg::CL_LBR:                 n = ist_pkg::ST_OPEN;
          ist_pkg::CL_PRN:                 n = ist_pkg::ST_KNAME;
          default:                         n = ist_pkg::ST_KDROP;
        endcase
      ist_pkg::ST_KNAME:
        unique case (cl)
          ist_pkg::CL_EOL:                 n = ist_pkg::ST_KLINE;
          ist_pkg::CL_EQ:                  n = ist_pkg::ST_AFTEQ;
          ist_pkg::CL_SP, ist_pkg::CL_PRN: n = ist_pkg::ST_KNAME;
          default:                         n = ist_pkg::ST_KDROP;
        endcase
      ist_pkg::ST_KDROP:
        n = (cl == ist_pkg::CL_EOL) ? ist_pkg::ST_KLINE : ist_pkg::ST_KDROP;
      ist_pkg::ST_AFTEQ:
        unique case (cl)
          ist_pkg::CL_EOL:                 n = ist_pkg::ST_KLINE;
          ist_pkg::CL_SP:                  n = ist_pkg::ST_AFTEQ;
          ist_pkg::CL_EQ, ist_pkg::CL_OTH: n = ist_pkg::ST_KDROP;
          default:                         n = ist_pkg::ST_VNAME;
        endcase
      ist_pkg::ST_VNAME:
        unique case (cl)
          ist_pkg::CL_EOL:                 n = ist_pkg::ST_KLINE;
          ist_pkg::CL_EQ, ist_pkg::CL_OTH: n = ist_pkg::ST_KDROP;
          default:                         n = ist_pkg::ST_VNAME;
        endcase
      default: n = ist_pkg::ST_LINE;
    endcase
    return n;
  endfunction

  // Advances the predictor by one request and returns the token it yields.
  function automatic ist_pkg::result_t tokenize(input logic [7:0] b, input logic eos);
    ist_pkg::result_t r;
    ist_pkg::state_t  st;
    ist_pkg::class_t  cl;
    logic             hold;
    r = '0;
    hold = 1'b0;
    st = (tok_state > ist_pkg::ST_VNAME) ? ist_pkg::ST_LINE : tok_state;
    if (eos) begin
      // End of text flushes a value in progress and restarts the parser.
      if (st == ist_pkg::ST_VNAME) r.event_res = ist_pkg::EV_PAIR;
      tok_state = ist_pkg::ST_LINE;
      held_spaces = '0;
    end else begin
      cl = byte_class(b);
      unique case (st)
        ist_pkg::ST_OPEN: begin
          if (cl == ist_pkg::CL_PRN) begin
            r.event_res = ist_pkg::EV_SEC;
            r.starts_name = 1'b1;
          end
        end
        ist_pkg::ST_SNAME: begin
          if (cl == ist_pkg::CL_PRN) r.event_res = ist_pkg::EV_SEC;
          else if (cl == ist_pkg::CL_SP) hold = 1'b1;
        end
        ist_pkg::ST_KLINE: begin
          if (cl == ist_pkg::CL_PRN) begin
            r.event_res = ist_pkg::EV_KEY;
            r.starts_name = 1'b1;
          end
        end
        ist_pkg::ST_KNAME: begin
          if (cl == ist_pkg::CL_PRN) r.event_res = ist_pkg::EV_KEY;
          else if (cl == ist_pkg::CL_SP) hold = 1'b1;
        end
        ist_pkg::ST_AFTEQ: begin
          if (cl == ist_pkg::CL_PRN || cl == ist_pkg::CL_LBR || cl == ist_pkg::CL_RBR) begin
            r.event_res = ist_pkg::EV_VAL;
            r.starts_name = 1'b1;
          end
        end
        ist_pkg::ST_VNAME: begin
          // Brackets are ordinary text inside a value.
          if (cl == ist_pkg::CL_PRN || cl == ist_pkg::CL_LBR || cl == ist_pkg::CL_RBR)
            r.event_res = ist_pkg::EV_VAL;
          else if (cl == ist_pkg::CL_SP) hold = 1'b1;
          else r.event_res = ist_pkg::EV_PAIR;
        end
        default: begin
        end
      endcase
      if (r.event_res == ist_pkg::EV_SEC || r.event_res == ist_pkg::EV_KEY ||
          r.event_res == ist_pkg::EV_VAL) begin
        r.char_out = b;
        r.spaces_before = r.starts_name ? 8'd0 : held_spaces;
      end
      // Inner spaces are counted up to saturation; anything else clears the count.
      if (hold) begin
        if (held_spaces != ist_pkg::SPACE_MAX) held_spaces = held_spaces + 8'd1;
      end else begin
        held_spaces = '0;
      end
      tok_state = follow(st, cl);
    end
    return r;
  endfunction

  // Counts one wrong field and reports the first few.
  task automatic note_mismatch(input string field, input int want, input int got);
    errors++;
    if (errors <= 10) begin
      $display("mismatch at token %0d, %s: expected %0d, got %0d", checked, field, want, got);
    end
  endtask

  // Compare delivered tokens first, then predict for the request taken at this edge.
  always @(posedge clk) begin : watch
    ist_pkg::result_t want;
    ist_pkg::result_t got;
    if (rst) begin
      token_q.delete();
      tok_state = ist_pkg::ST_LINE;
      held_spaces = '0;
      errors = 0;
      checked = 0;
      pairs = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[15:8], m_tuser[3], m_tdata[7:0], m_tuser[2:0]};
        if (token_q.size() == 0) begin
          note_mismatch("token with nothing predicted, event", -1, got.event_res);
        end else begin
          want = token_q.pop_front();
          if (want.event_res == ist_pkg::EV_PAIR) pairs++;
          if (got.event_res != want.event_res)
            note_mismatch("event_res", want.event_res, got.event_res);
          if (got.char_out != want.char_out)
            note_mismatch("char_out", want.char_out, got.char_out);
          if (got.starts_name != want.starts_name)
            note_mismatch("starts_name", want.starts_name, got.starts_name);
          if (got.spaces_before != want.spaces_before)
            note_mismatch("spaces_before", want.spaces_before, got.spaces_before);
          checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        token_q.push_back(tokenize(s_tdata, s_tlast));
      end
    end
    pending <= token_q.size();
  end

endmodule

// ===== bench/ini_stream_tokenizer_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ini_stream_tokenizer_test
// Feeds the INI tokenizer a short hand-written text that walks through its
// corner cases, then a long random text of sections, key/value lines, broken
// lines and byte noise, with random stalls on both channels. A separate
// checker predicts and compares every token.
// ---------------------------------------------------------------------------
module ini_stream_tokenizer_test;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [3:0]  m_tuser;

  int errors;
  int pending;
  int checked;
  int pairs;

  // Text to send: {end_of_stream, byte}.
  logic [8:0] text_q[$];
  int  sent = 0;
  bit  calm = 1'b0;

  always #5 clk = ~clk;

  ini_stream_tokenizer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  ini_stream_tokenizer_check u_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked),
    .pairs    (pairs)
  );

  task automatic add_byte(input logic [7:0] b);
    text_q.push_back({1'b0, b});
  endtask

  task automatic add_eos();
    text_q.push_back({1'b1, 8'($urandom_range(0, 255))});
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_spaces(input int n);
    for (int i = 0; i < n; i++) add_byte(ist_pkg::CH_SP);
  endtask

  task automatic add_eol();
    add_byte($urandom_range(0, 1) ? ist_pkg::CH_LF : ist_pkg::CH_CR);
  endtask

  // A byte of the "other" class: control codes and everything from 127 up.
  function automatic logic [7:0] other_byte();
    logic [7:0] b;
    b = $urandom_range(0, 1) ? 8'($urandom_range(127, 255)) : 8'($urandom_range(0, 31));
    if (b == ist_pkg::CH_LF || b == ist_pkg::CH_CR) b = 8'h00;
    return b;
  endfunction

  // A printable name character; values may also hold brackets.
  function automatic logic [7:0] name_char(input bit in_value);
    logic [7:0] c;
    c = 8'($urandom_range(33, 126));
    while (c == ist_pkg::CH_LBR || c == ist_pkg::CH_RBR || c == ist_pkg::CH_EQ)
      c = 8'($urandom_range(33, 126));
    if (in_value && $urandom_range(0, 9) == 0)
      c = $urandom_range(0, 1) ? ist_pkg::CH_LBR : ist_pkg::CH_RBR;
    return c;
  endfunction

  // A short name with an occasional run of inner spaces, rarely a long one.
  task automatic add_name(input bit in_value);
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 120) == 0) add_spaces($urandom_range(200, 300));
        else add_spaces($urandom_range(1, 3));
      end
      add_byte(name_char(in_value));
    end
  endtask

  // One random line of INI text, mostly well formed.
  task automatic add_line();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 14) begin
      // Section header, sometimes with text after the bracket.
      add_byte(ist_pkg::CH_LBR);
      add_spaces($urandom_range(0, 2));
      add_name(1'b0);
      add_spaces($urandom_range(0, 2));
      add_byte(ist_pkg::CH_RBR);
      if ($urandom_range(0, 3) == 0) add_name(1'b1);
      add_eol();
    end else if (r < 74) begin
      // Key/value line; a few values end on '=' or a bad byte.
      add_spaces($urandom_range(0, 2));
      add_name(1'b0);
      add_spaces($urandom_range(0, 2));
      add_byte(ist_pkg::CH_EQ);
      add_spaces($urandom_range(0, 2));
      add_name(1'b1);
      add_spaces($urandom_range(0, 2));
      if ($urandom_range(0, 99) < 15) begin
        add_byte($urandom_range(0, 1) ? ist_pkg::CH_EQ : other_byte());
        add_name(1'b1);
      end
      add_eol();
    end else if (r < 84) begin
      // Raw byte noise.
      k = $urandom_range(1, 8);
      for (int i = 0; i < k; i++) add_byte(8'($urandom_range(0, 255)));
      add_eol();
    end else if (r < 93) begin
      // Broken lines of several kinds.
      k = $urandom_range(0, 4);
      case (k)
        0: begin
          add_name(1'b0);
        end
        1: begin
          add_byte(ist_pkg::CH_LBR);
          add_name(1'b0);
        end
        2: begin
          add_byte(ist_pkg::CH_LBR);
          add_name(1'b0);
          add_byte(ist_pkg::CH_EQ);
          add_name(1'b0);
          add_byte(ist_pkg::CH_RBR);
        end
        3: begin
          add_name(1'b0);
          add_byte(ist_pkg::CH_LBR);
          add_name(1'b0);
          add_byte(ist_pkg::CH_EQ);
          add_name(1'b1);
        end
        default: begin
          add_name(1'b0);
          add_byte(ist_pkg::CH_EQ);
        end
      endcase
      add_eol();
    end else if (r < 98) begin
      add_spaces($urandom_range(0, 3));
      add_eol();
    end else begin
      add_eos();
    end
  endtask

  // Sends the queued text, with sender gaps except in quiet stretches and the tail.
  task automatic send_text();
    logic [8:0] it;
    while (text_q.size() > 0) begin
      it = text_q.pop_front();
      calm = (text_q.size() < 250);
      if (!calm && ((sent >> 7) % 3) != 0 && $urandom_range(0, 5) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= it[7:0];
      s_tlast  <= it[8];
      do @(posedge clk); while (!s_tready);
      sent++;
    end
    s_tvalid <= 1'b0;
  endtask

  // Receiver stalls in bursts, with calm, light and heavy stretches.
  initial begin : sink
    int hold;
    int span;
    int mode;
    hold = 0;
    span = 0;
    mode = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = 200;
      end
      span--;
      if (hold > 0 && !calm) begin
        hold--;
      end else if (!calm && mode != 0 && $urandom_range(0, (mode == 1) ? 15 : 4) == 0) begin
        m_tready <= 1'b0;
        hold = $urandom_range(0, 15);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stim
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Header with spaces and text after the bracket.
    add_text("[ s ]x\n");
    // Held spaces inside a key and a value; the value ends on a bad byte.
    add_text("k  v=a b");
    add_byte(8'hFF);
    add_text("\n");
    // Key line starting with '=', then an empty value.
    add_text("=");
    add_byte(8'h00);
    add_text("\nk=\n");
    // Value cut off by end of stream.
    add_text("k=v");
    text_q.push_back({1'b1, 8'hFF});
    // Bad header, after which a key is not taken.
    add_text("[a=\nk\r");
    send_text();

    // Saturating space count, then random text.
    add_text("[sat]\nk=a");
    add_spaces(260);
    add_text("b\n");
    while (text_q.size() < 1850) add_line();
    add_eos();
    send_text();

    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);

    $display("sent %0d requests, checked %0d tokens, %0d of them completed pairs",
             sent, checked, pairs);
    $display("covered: hand-written corner cases, saturated space runs, random INI text");
    if (errors == 0 && pending == 0) begin
      $display("ini_stream_tokenizer_test: done, clean");
    end else begin
      $display("%0d mismatches, %0d tokens missing", errors, pending);
      $display("ini_stream_tokenizer_test: done, errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d tokens outstanding", pending);
    $display("ini_stream_tokenizer_test: done, errors");
    $finish;
  end

endmodule
